// File: rtl/core/noc_pkg.sv
package noc_pkg;

  // Field widths of the transfer payloads
  localparam int TEXT_W  = 64;
  localparam int LEN_W   = 4;
  localparam int TEXT_BYTES = TEXT_W / 8;
  localparam int BYTE_IDX_W = $clog2(TEXT_BYTES);

  // Default and largest name length in bytes
  localparam int MAX_LENGTH_DEF = 8;

  // A run of at most eight digits stays below 10^8 < 2^27
  localparam int VAL_W = 27;

  // Character constants
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = DIGIT_ZERO + 8'd9;
  localparam int         RADIX      = 10;

  // Sequencer state codes
  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STATE_W-1:0] ST_CMP  = 2'd1;
  localparam logic [STATE_W-1:0] ST_NUM  = 2'd2;
  localparam logic [STATE_W-1:0] ST_FIN  = 2'd3;

  // Command to one lane
  typedef struct packed {
    logic adv;   // step over one character
    logic acc;   // fold the current digit into the run value
    logic clr;   // clear the run value
  } lane_cmd_t;

  // Status of one lane
  typedef struct packed {
    logic             at_end;
    logic             digit;
    logic [7:0]       ch;
    logic [VAL_W-1:0] val;
  } lane_stat_t;

  // Decision from the merge stage
  typedef struct packed {
    logic [STATE_W-1:0] next_state;
    logic               res_load;
    logic               res;
  } decide_t;

endpackage

// File: rtl/core/noc_if.sv
// Input channel: one pair of names per transfer
interface noc_in_if;
  logic                          valid;
  logic                          ready;
  logic [noc_pkg::TEXT_W-1:0]    left_text;
  logic [noc_pkg::LEN_W-1:0]     left_length;
  logic [noc_pkg::TEXT_W-1:0]    right_text;
  logic [noc_pkg::LEN_W-1:0]     right_length;

  modport source (output valid, left_text, left_length, right_text, right_length,
                  input ready);
  modport sink   (input valid, left_text, left_length, right_text, right_length,
                  output ready);
endinterface

// Output channel: one compare result per transfer
interface noc_out_if;
  logic valid;
  logic ready;
  logic left_is_less;

  modport source (output valid, left_is_less, input ready);
  modport sink   (input valid, left_is_less, output ready);
endinterface

// File: rtl/core/noc_lane.sv
// One name scanner: walks its name byte by byte and builds digit run values
module noc_lane #(
  parameter int MAX_LENGTH = noc_pkg::MAX_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [noc_pkg::TEXT_W-1:0] text,
  input  logic [noc_pkg::LEN_W-1:0]  len,
  input  noc_pkg::lane_cmd_t         cmd,
  output noc_pkg::lane_stat_t        stat
);

  localparam logic [noc_pkg::LEN_W-1:0] MAX_LEN = noc_pkg::LEN_W'(MAX_LENGTH);

  logic [noc_pkg::TEXT_W-1:0] txt;
  logic [noc_pkg::LEN_W-1:0]  lim;
  logic [noc_pkg::LEN_W-1:0]  pos;
  logic [noc_pkg::VAL_W-1:0]  val;
  logic [noc_pkg::VAL_W-1:0]  val_next;
  logic [7:0]                 ch;
  logic [3:0]                 dval;

  // Current character
  assign ch   = txt[{pos[noc_pkg::BYTE_IDX_W-1:0], 3'b000} +: 8];
  assign dval = 4'(ch - noc_pkg::DIGIT_ZERO);

  // Decimal accumulate
  assign val_next = noc_pkg::VAL_W'(val * noc_pkg::VAL_W'(noc_pkg::RADIX))
                  + noc_pkg::VAL_W'(dval);

  // Name registers, position and run value
  always_ff @(posedge clk) begin
    if (load) begin
      txt <= text;
      lim <= (len > MAX_LEN) ? MAX_LEN : len;
      pos <= '0;
      val <= '0;
    end else begin
      if (cmd.adv || cmd.acc) begin
        pos <= pos + 1'b1;
      end
      if (cmd.acc) begin
        val <= val_next;
      end else if (cmd.clr) begin
        val <= '0;
      end
    end
  end

  assign stat.at_end = (pos >= lim);
  assign stat.digit  = (ch >= noc_pkg::DIGIT_ZERO) && (ch <= noc_pkg::DIGIT_NINE);
  assign stat.ch     = ch;
  assign stat.val    = val;

endmodule

// File: rtl/core/noc_merge.sv
// Merge stage: compares the tokens the two lanes present and steers them
module noc_merge (
  input  logic [noc_pkg::STATE_W-1:0] state,
  input  noc_pkg::lane_stat_t         lstat,
  input  noc_pkg::lane_stat_t         rstat,
  output noc_pkg::lane_cmd_t          lcmd,
  output noc_pkg::lane_cmd_t          rcmd,
  output noc_pkg::decide_t            dec
);

  logic lrun;
  logic rrun;

  // A lane keeps reading its digit run until it ends
  assign lrun = lstat.digit && !lstat.at_end;
  assign rrun = rstat.digit && !rstat.at_end;

  always_comb begin
    lcmd = '0;
    rcmd = '0;
    dec.next_state = state;
    dec.res_load   = 1'b0;
    dec.res        = 1'b0;
    case (state)
      noc_pkg::ST_CMP: begin
        if (lstat.at_end || rstat.at_end) begin
          // tie so far: left is less only if right has more
          dec.res_load   = 1'b1;
          dec.res        = !rstat.at_end;
          dec.next_state = noc_pkg::ST_FIN;
        end else if (lstat.digit && rstat.digit) begin
          dec.next_state = noc_pkg::ST_NUM;
        end else if (lstat.digit || rstat.digit) begin
          // number sorts before character
          dec.res_load   = 1'b1;
          dec.res        = lstat.digit;
          dec.next_state = noc_pkg::ST_FIN;
        end else if (lstat.ch != rstat.ch) begin
          dec.res_load   = 1'b1;
          dec.res        = $signed(lstat.ch) < $signed(rstat.ch);
          dec.next_state = noc_pkg::ST_FIN;
        end else begin
          lcmd.adv = 1'b1;
          rcmd.adv = 1'b1;
        end
      end
      noc_pkg::ST_NUM: begin
        if (lrun || rrun) begin
          lcmd.acc = lrun;
          rcmd.acc = rrun;
        end else if (lstat.val != rstat.val) begin
          dec.res_load   = 1'b1;
          dec.res        = lstat.val < rstat.val;
          dec.next_state = noc_pkg::ST_FIN;
        end else begin
          // equal values: drop both runs and go on
          lcmd.clr       = 1'b1;
          rcmd.clr       = 1'b1;
          dec.next_state = noc_pkg::ST_CMP;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/natural_order_compare_core.sv
// Channel     Dir  Payload                                            Handshake
// pair_in     in   left_text, left_length, right_text, right_length   valid/ready
// result_out  out  left_is_less                                       valid/ready
//
// One pair is worked at a time. After the pair transfers, the lanes step one byte
// per cycle, and each digit run is spotted in the compare state and its value
// compared in the number state.
// The next pair can transfer in the cycle after its predecessor's result is registered.
// Reset (rst, synchronous) empties the sequencer and the output register.
// A finished pair holds in the final state while the output register is full and not taken.
module natural_order_compare_core #(
  parameter int MAX_LENGTH = noc_pkg::MAX_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  noc_in_if.sink     pair_in,
  noc_out_if.source  result_out
);

  logic [noc_pkg::STATE_W-1:0] state;
  logic [noc_pkg::STATE_W-1:0] state_next;
  logic                        res;
  logic                        ov;
  logic                        od;
  logic                        accept;
  logic                        slot_free;
  noc_pkg::lane_cmd_t          lcmd;
  noc_pkg::lane_cmd_t          rcmd;
  noc_pkg::lane_stat_t         lstat;
  noc_pkg::lane_stat_t         rstat;
  noc_pkg::decide_t            dec;

  assign pair_in.ready = (state == noc_pkg::ST_IDLE);
  assign accept        = pair_in.valid && pair_in.ready;
  assign slot_free     = !ov || result_out.ready;

  // Scanner lanes
  noc_lane #(.MAX_LENGTH(MAX_LENGTH)) u_left (
    .clk  (clk),
    .load (accept),
    .text (pair_in.left_text),
    .len  (pair_in.left_length),
    .cmd  (lcmd),
    .stat (lstat)
  );

  noc_lane #(.MAX_LENGTH(MAX_LENGTH)) u_right (
    .clk  (clk),
    .load (accept),
    .text (pair_in.right_text),
    .len  (pair_in.right_length),
    .cmd  (rcmd),
    .stat (rstat)
  );

  // Token compare
  noc_merge u_merge (
    .state (state),
    .lstat (lstat),
    .rstat (rstat),
    .lcmd  (lcmd),
    .rcmd  (rcmd),
    .dec   (dec)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      noc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = noc_pkg::ST_CMP;
        end
      end
      noc_pkg::ST_CMP, noc_pkg::ST_NUM: begin
        state_next = dec.next_state;
      end
      noc_pkg::ST_FIN: begin
        if (slot_free) begin
          state_next = noc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = noc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= noc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decided result
  always_ff @(posedge clk) begin
    if (dec.res_load) begin
      res <= dec.res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == noc_pkg::ST_FIN && slot_free) begin
      ov <= 1'b1;
    end else if (result_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == noc_pkg::ST_FIN && slot_free) begin
      od <= res;
    end
  end

  assign result_out.valid        = ov;
  assign result_out.left_is_less = od;

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == noc_pkg::ST_CMP))
    else $error("accepted pair did not start the compare");

  a_num_entry: assert property (@(posedge clk) disable iff (rst)
    (state == noc_pkg::ST_CMP && state_next == noc_pkg::ST_NUM)
    |=> (lstat.digit && rstat.digit && !lstat.at_end && !rstat.at_end
         && lstat.val == '0 && rstat.val == '0))
    else $error("number compare entered without two fresh digit runs");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> ($past(state) == noc_pkg::ST_FIN))
    else $error("result presented without a finished compare");

endmodule

// File: verif/natural_order_compare_core_test.sv
`timescale 1ns / 1ps

module natural_order_compare_core_test;
  import noc_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_CYCLES = 8;
  localparam int RANDOM_PAIRS = 1050;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2 * MAX_LENGTH_DEF + 24;
  localparam int RUN_LIMIT_NS = 12_000_000;

  logic clk;
  logic rst;
  bit   long_hold_req;

  noc_in_if  pair_if ();
  noc_out_if res_if ();

  natural_order_compare_core dut (
    .clk        (clk),
    .rst        (rst),
    .pair_in    (pair_if),
    .result_out (res_if)
  );

  // One pair in flight, with the answer it should produce
  typedef struct {
    logic [TEXT_W-1:0] left_text;
    logic [LEN_W-1:0]  left_length;
    logic [TEXT_W-1:0] right_text;
    logic [LEN_W-1:0]  right_length;
    bit                left_is_less;
  } pair_expect_t;

  class compare_scoreboard;
    pair_expect_t expected_q[$];
    int           mismatches;

    static function bit is_digit(logic [7:0] b);
      return b >= DIGIT_ZERO && b <= DIGIT_NINE;
    endfunction

    // Natural-order "left < right": digit runs compare by value, a number
    // sorts before a character, characters compare as signed bytes.
    static function bit natural_less(logic [TEXT_W-1:0] lt, logic [LEN_W-1:0] ll,
                                     logic [TEXT_W-1:0] rt, logic [LEN_W-1:0] rl);
      int          ln, rn, lp, rp;
      logic [7:0]  lb, rb;
      bit          ld, rd, done, res;
      int unsigned lv, rv;
      ln = (ll > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : int'(ll);
      rn = (rl > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : int'(rl);
      lp = 0;
      rp = 0;
      done = 1'b0;
      res = 1'b0;
      while (!done && lp < ln && rp < rn) begin
        lb = lt[8*lp +: 8];
        rb = rt[8*rp +: 8];
        ld = is_digit(lb);
        rd = is_digit(rb);
        if (ld && rd) begin
          lv = 0;
          rv = 0;
          while (lp < ln && is_digit(lt[8*lp +: 8])) begin
            lv = lv * RADIX + (lt[8*lp +: 8] - DIGIT_ZERO);
            lp++;
          end
          while (rp < rn && is_digit(rt[8*rp +: 8])) begin
            rv = rv * RADIX + (rt[8*rp +: 8] - DIGIT_ZERO);
            rp++;
          end
          if (lv != rv) begin
            res = lv < rv;
            done = 1'b1;
          end
        end else if (ld) begin
          res = 1'b1;
          done = 1'b1;
        end else if (rd) begin
          res = 1'b0;
          done = 1'b1;
        end else if (lb != rb) begin
          res = $signed(lb) < $signed(rb);
          done = 1'b1;
        end else begin
          lp++;
          rp++;
        end
      end
      // all tokens tied: less only if the right name has more left
      if (!done) res = rp < rn;
      return res;
    endfunction

    function void note_pair(logic [TEXT_W-1:0] lt, logic [LEN_W-1:0] ll,
                            logic [TEXT_W-1:0] rt, logic [LEN_W-1:0] rl);
      pair_expect_t e;
      e.left_text = lt;
      e.left_length = ll;
      e.right_text = rt;
      e.right_length = rl;
      e.left_is_less = natural_less(lt, ll, rt, rl);
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_result(logic actual);
      pair_expect_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no pair pending: expected none, actual left_is_less=%b",
                 $time, actual);
        mismatches++;
      end else begin
        e = expected_q.pop_front();
        if (actual !== e.left_is_less) begin
          $display("%0t: left_is_less for %h/%0d vs %h/%0d: expected %b, actual %b",
                   $time, e.left_text, e.left_length, e.right_text, e.right_length,
                   e.left_is_less, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  compare_scoreboard sb;

  // Clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Pack a name, filling bytes past its length with junk
  function automatic logic [TEXT_W-1:0] pack_name(string s);
    logic [TEXT_W-1:0] t;
    t = {$urandom, $urandom};
    for (int i = 0; i < s.len() && i < TEXT_BYTES; i++) t[8*i +: 8] = s[i];
    return t;
  endfunction

  // Byte mix biased toward digit runs, zeros and a few repeated letters
  function automatic logic [7:0] name_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return DIGIT_ZERO;
    if (r < 55) return DIGIT_ZERO + 8'($urandom_range(9));
    if (r < 80) begin
      case ($urandom_range(3))
        0: return "a";
        1: return "b";
        2: return ".";
        default: return "-";
      endcase
    end
    if (r < 90) return "A" + 8'($urandom_range(25));
    return 8'($urandom);
  endfunction

  // Mostly well-formed pairs, often near copies so ties run deep
  function automatic void random_pair(output logic [TEXT_W-1:0] lt, output logic [LEN_W-1:0] ll,
                                      output logic [TEXT_W-1:0] rt, output logic [LEN_W-1:0] rl);
    int               kind, pos;
    logic [TEXT_W-1:0] swap_t;
    logic [LEN_W-1:0]  swap_l;
    kind = $urandom_range(99);
    lt = {$urandom, $urandom};
    rt = {$urandom, $urandom};
    ll = LEN_W'($urandom_range(MAX_LENGTH_DEF));
    rl = LEN_W'($urandom_range(MAX_LENGTH_DEF));
    if (kind < 12) begin
      // raw noise, lengths past the bound included
      ll = LEN_W'($urandom_range(15));
      rl = LEN_W'($urandom_range(15));
    end else begin
      for (int k = 0; k < TEXT_BYTES; k++) lt[8*k +: 8] = name_byte();
      if (kind < 65) begin
        rt = lt;
        rl = ll;
        pos = $urandom_range(TEXT_BYTES - 1);
        case ($urandom_range(4))
          0: rt[8*pos +: 8] = name_byte();
          1: rl = LEN_W'($urandom_range(MAX_LENGTH_DEF));
          2: ;
          3: rt[8*pos +: 8] = ($urandom_range(1) != 0) ? lt[8*pos +: 8] + 8'd1
                                                         : lt[8*pos +: 8] - 8'd1;
          default: begin
            // leading zero in front of the name
            rt = {lt[TEXT_W-9:0], DIGIT_ZERO};
            rl = (ll < MAX_LENGTH_DEF) ? ll + 4'd1 : 4'(MAX_LENGTH_DEF);
          end
        endcase
        if ($urandom_range(1) != 0) begin
          swap_t = lt; lt = rt; rt = swap_t;
          swap_l = ll; ll = rl; rl = swap_l;
        end
      end else begin
        for (int k = 0; k < TEXT_BYTES; k++) rt[8*k +: 8] = name_byte();
      end
      if ($urandom_range(99) < 4) ll = LEN_W'($urandom_range(15, MAX_LENGTH_DEF + 1));
      if ($urandom_range(99) < 4) rl = LEN_W'($urandom_range(15, MAX_LENGTH_DEF + 1));
    end
  endfunction

  // Offer one pair and hold it until the transfer
  task automatic send_pair(logic [TEXT_W-1:0] lt, logic [LEN_W-1:0] ll,
                           logic [TEXT_W-1:0] rt, logic [LEN_W-1:0] rl);
    @(negedge clk);
    pair_if.valid        <= 1'b1;
    pair_if.left_text    <= lt;
    pair_if.left_length  <= ll;
    pair_if.right_text   <= rt;
    pair_if.right_length <= rl;
    do @(posedge clk); while (!pair_if.ready);
    sb.note_pair(lt, ll, rt, rl);
  endtask

  task automatic send_names(string l, string r);
    send_pair(pack_name(l), 4'(l.len()), pack_name(r), 4'(r.len()));
  endtask

  // Idle the input for a while; steady mode offers back to back
  task automatic input_gap(bit steady);
    int r, n;
    r = $urandom_range(99);
    n = 0;
    if (!steady) begin
      if (r >= 90)      n = $urandom_range(30, 6);
      else if (r >= 55) n = $urandom_range(3, 1);
    end
    if (n > 0) begin
      @(negedge clk);
      pair_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) sb.check_result(res_if.left_is_less);
  end

  // Result side: random stalls, steady stretches, and long hold-offs on request
  initial begin : result_sink
    int stall_left, mode_cycles;
    bit steady;
    stall_left = 0;
    mode_cycles = 0;
    steady = 1'b0;
    res_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (mode_cycles == 0) begin
        steady = ($urandom_range(3) == 0);
        mode_cycles = 256;
      end
      mode_cycles--;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !steady && $urandom_range(99) < 30) begin
        stall_left = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 8);
      end
      res_if.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
      @(negedge clk);
    end
  end

  // Run limit
  initial begin
    #RUN_LIMIT_NS;
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [TEXT_W-1:0] lt, rt;
    logic [LEN_W-1:0]  ll, rl;
    bit                steady;
    sb = new();
    long_hold_req = 1'b0;
    rst = 1'b1;
    pair_if.valid = 1'b0;
    pair_if.left_text = '0;
    pair_if.left_length = '0;
    pair_if.right_text = '0;
    pair_if.right_length = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empties, ties, numeric runs, number vs char, signed bytes
    send_names("", "");
    send_names("", "a");
    send_names("a", "");
    send_names("abc", "abc");
    input_gap(1'b0);
    send_names("a2", "a10");
    send_names("a10", "a2");
    send_names("007", "7");
    send_names("007x", "7y");
    send_names("1", "a");
    input_gap(1'b0);
    send_names("a", "1");
    send_pair(64'h0000_0000_0000_0080, 4'd1, 64'h0000_0000_0000_007F, 4'd1);
    send_pair(64'h0000_0000_0000_007F, 4'd1, 64'h0000_0000_0000_0080, 4'd1);
    send_names("99999999", "99999998");
    send_names("99999998", "99999999");
    send_names("00000000", "0");
    input_gap(1'b0);
    send_names("ab", "abc");
    send_names("/", "0");
    send_names(":", "9");
    send_names("x12y", "x12z");
    // all-ones against all-zeros, and lengths past the bound
    send_pair({TEXT_W{1'b1}}, 4'd8, {TEXT_W{1'b0}}, 4'd8);
    send_pair({TEXT_W{1'b0}}, 4'd0, {TEXT_W{1'b1}}, 4'd15);
    lt = pack_name("abcdefgh");
    send_pair(lt, 4'd15, lt, 4'd8);
    send_pair(lt, 4'd9, lt, 4'd12);
    send_pair(lt, 4'd8, lt, 4'd9);

    // Random pairs; the result side holds off long twice to back up the input
    long_hold_req = 1'b1;
    steady = 1'b0;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 150 == 0) steady = ($urandom_range(2) == 0);
      if (i == RANDOM_PAIRS / 2) long_hold_req = 1'b1;
      random_pair(lt, ll, rt, rl);
      send_pair(lt, ll, rt, rl);
      input_gap(steady);
    end
    @(negedge clk);
    pair_if.valid <= 1'b0;

    // Drain, then wait on to catch stray results
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
